>>> src/tcs_pkg.sv
// Shared types, constants and per-stage helper functions for the touch calibration scaler.
package tcs_pkg;

	localparam int ADC_BITS = 12;
	localparam int PROD_BITS = 2 * ADC_BITS;
	localparam int DIV_STEPS = ADC_BITS;
	localparam int NUM_REGS = 7;
	localparam int REG_IDX_BITS = $clog2(NUM_REGS);
	localparam int IN_TDATA_BITS = ((3 * ADC_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = ((2 * ADC_BITS + 7) / 8) * 8;

	typedef logic [ADC_BITS-1:0] raw_t;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_X_RAW_MIN       = 3'd0,
		REG_X_RAW_MAX       = 3'd1,
		REG_Y_RAW_MIN       = 3'd2,
		REG_Y_RAW_MAX       = 3'd3,
		REG_X_SPAN          = 3'd4,
		REG_Y_SPAN          = 3'd5,
		REG_PRESS_THRESHOLD = 3'd6
	} reg_idx_t;

	localparam raw_t X_RAW_MIN_RST = raw_t'(3610);
	localparam raw_t X_RAW_MAX_RST = raw_t'(330);
	localparam raw_t Y_RAW_MIN_RST = raw_t'(3640);
	localparam raw_t Y_RAW_MAX_RST = raw_t'(510);
	localparam raw_t X_SPAN_RST    = raw_t'(319);
	localparam raw_t Y_SPAN_RST    = raw_t'(239);
	localparam raw_t PRESS_THR_RST = raw_t'(10);

	// Axis after the clamp decode: offset from the calibration edge and its distance
	typedef struct packed {
		logic zero;
		raw_t span;
		raw_t delta;
		raw_t off;
	} axis_pre_t;

	// Axis inside the divider: remainder, and dividend bits shifting out as quotient bits shift in
	typedef struct packed {
		logic zero;
		logic sat;
		raw_t span;
		raw_t delta;
		raw_t rem;
		raw_t work;
	} axis_div_t;

	typedef struct packed {
		axis_pre_t x;
		axis_pre_t y;
		logic      touched;
	} pre_stage_t;

	typedef struct packed {
		axis_div_t x;
		axis_div_t y;
		logic      touched;
	} div_stage_t;

	// Decode the pair direction, the clamp at the near edge and the offset
	function automatic axis_pre_t axis_pre(input raw_t raw, input raw_t lo, input raw_t hi,
		input raw_t span);
		axis_pre_t p;
		logic      rising;
		rising  = lo < hi;
		p.span  = span;
		p.delta = rising ? hi - lo : lo - hi;
		p.zero  = rising ? (raw < lo) : (raw >= lo);
		p.off   = rising ? raw - lo : lo - raw;
		return p;
	endfunction

	// Form offset times span and load the divider
	function automatic axis_div_t axis_load(input axis_pre_t p);
		axis_div_t             d;
		logic [PROD_BITS-1:0] prod;
		prod    = {{ADC_BITS{1'b0}}, p.off} * {{ADC_BITS{1'b0}}, p.span};
		d.zero  = p.zero;
		d.sat   = p.off > p.delta;
		d.span  = p.span;
		d.delta = p.delta;
		d.rem   = prod[PROD_BITS-1:ADC_BITS];
		d.work  = prod[ADC_BITS-1:0];
		return d;
	endfunction

	// One restoring division step: one quotient bit
	function automatic axis_div_t div_step(input axis_div_t a);
		axis_div_t         r;
		logic [ADC_BITS:0] cand;
		logic [ADC_BITS:0] diff;
		logic              take;
		cand   = {a.rem, a.work[ADC_BITS-1]};
		diff   = cand - {1'b0, a.delta};
		take   = cand >= {1'b0, a.delta};
		r      = a;
		r.rem  = take ? diff[ADC_BITS-1:0] : cand[ADC_BITS-1:0];
		r.work = {a.work[ADC_BITS-2:0], take};
		return r;
	endfunction

	// Pick the clamped edge or the quotient
	function automatic raw_t axis_pos(input axis_div_t d);
		raw_t pos;
		if (d.zero) begin
			pos = '0;
		end else if (d.sat) begin
			pos = d.span;
		end else begin
			pos = d.work;
		end
		return pos;
	endfunction

endpackage

>>> src/touch_calibration_scaler_core.sv
// Top level of the touch calibration scaler: pipelined clamp, multiply and divide per axis.
//
// Usage: raw touch samples enter on the s_ stream (X, Y and pressure conversions packed in
// s_tdata); one calibrated result leaves on the m_ stream for every sample, in order, with
// X and Y screen coordinates in m_tdata and the touch flag in m_tuser. Calibration registers
// are written through the cfg_ channel (cfg_index selects the register, cfg_data the value);
// cfg_ready is always high and an index beyond the register list is ignored. Write the
// registers only while no sample is in flight.
// Throughput: one sample per clock while m_tready is high. A sample passes through
// the front decode stage, the multiply stage, the twelve one-bit divider stages (one
// per quotient bit) and the output register on its way to m_tvalid.
// Reset: arst_n clears every valid bit and loads the calibration defaults (X 3610..330,
// Y 3640..510, spans 319 and 239, pressure threshold 10).
// Stall: when m_tready is low the result holds; each stage keeps filling while a bubble lies
// ahead of it, so s_tready falls only once every stage holds a sample.
module touch_calibration_scaler_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// input samples
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tcs_pkg::IN_TDATA_BITS-1:0] s_tdata,  // raw_x, raw_y, raw_pressure, zero pad
	// calibrated results
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tcs_pkg::OUT_TDATA_BITS-1:0] m_tdata, // x_pos, y_pos
	output logic                              m_tuser,  // touched
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tcs_pkg::REG_IDX_BITS-1:0]  cfg_index,
	input  logic [tcs_pkg::ADC_BITS-1:0]      cfg_data
);
	import tcs_pkg::*;

	raw_t x_raw_min_q;
	raw_t x_raw_max_q;
	raw_t y_raw_min_q;
	raw_t y_raw_max_q;
	raw_t x_span_q;
	raw_t y_span_q;
	raw_t press_thr_q;

	raw_t raw_x;
	raw_t raw_y;
	raw_t raw_pressure;

	logic       vld_s1;
	pre_stage_t dat_s1;
	logic       rdy_s1;
	logic       vld_s2;
	div_stage_t dat_s2;
	logic       rdy_s2;

	// element k is pipeline stage s(3+k), holding the state after k+1 quotient bits
	logic       div_vld_s3 [DIV_STEPS];
	div_stage_t div_s3     [DIV_STEPS];
	logic       div_rdy    [DIV_STEPS];

	logic       out_rdy;
	logic       m_tvalid_q;
	raw_t       x_pos_q;
	raw_t       y_pos_q;
	logic       touched_q;

	assign raw_x        = s_tdata[ADC_BITS-1:0];
	assign raw_y        = s_tdata[2*ADC_BITS-1:ADC_BITS];
	assign raw_pressure = s_tdata[3*ADC_BITS-1:2*ADC_BITS];

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_raw_min_q <= X_RAW_MIN_RST;
			x_raw_max_q <= X_RAW_MAX_RST;
			y_raw_min_q <= Y_RAW_MIN_RST;
			y_raw_max_q <= Y_RAW_MAX_RST;
			x_span_q    <= X_SPAN_RST;
			y_span_q    <= Y_SPAN_RST;
			press_thr_q <= PRESS_THR_RST;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_X_RAW_MIN:       x_raw_min_q <= cfg_data;
				REG_X_RAW_MAX:       x_raw_max_q <= cfg_data;
				REG_Y_RAW_MIN:       y_raw_min_q <= cfg_data;
				REG_Y_RAW_MAX:       y_raw_max_q <= cfg_data;
				REG_X_SPAN:          x_span_q    <= cfg_data;
				REG_Y_SPAN:          y_span_q    <= cfg_data;
				REG_PRESS_THRESHOLD: press_thr_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Stage ready chain: a stage loads when it is empty or its content moves on
	always_comb begin
		out_rdy = !m_tvalid_q || m_tready;
		div_rdy[DIV_STEPS-1] = !div_vld_s3[DIV_STEPS-1] || out_rdy;
		for (int k = DIV_STEPS - 2; k >= 0; k--) begin
			div_rdy[k] = !div_vld_s3[k] || div_rdy[k+1];
		end
		rdy_s2 = !vld_s2 || div_rdy[0];
		rdy_s1 = !vld_s1 || rdy_s2;
	end

	assign s_tready = rdy_s1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int k = 0; k < DIV_STEPS; k++) begin
				div_vld_s3[k] <= 1'b0;
			end
		end else begin
			if (rdy_s1) begin
				vld_s1 <= s_tvalid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (div_rdy[0]) begin
				div_vld_s3[0] <= vld_s2;
			end
			for (int k = 1; k < DIV_STEPS; k++) begin
				if (div_rdy[k]) begin
					div_vld_s3[k] <= div_vld_s3[k-1];
				end
			end
			if (out_rdy) begin
				m_tvalid_q <= div_vld_s3[DIV_STEPS-1];
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			dat_s1.x       <= axis_pre(raw_x, x_raw_min_q, x_raw_max_q, x_span_q);
			dat_s1.y       <= axis_pre(raw_y, y_raw_min_q, y_raw_max_q, y_span_q);
			dat_s1.touched <= raw_pressure > press_thr_q;
		end
		if (rdy_s2 && vld_s1) begin
			dat_s2.x       <= axis_load(dat_s1.x);
			dat_s2.y       <= axis_load(dat_s1.y);
			dat_s2.touched <= dat_s1.touched;
		end
		if (div_rdy[0] && vld_s2) begin
			div_s3[0].x       <= div_step(dat_s2.x);
			div_s3[0].y       <= div_step(dat_s2.y);
			div_s3[0].touched <= dat_s2.touched;
		end
		for (int k = 1; k < DIV_STEPS; k++) begin
			if (div_rdy[k] && div_vld_s3[k-1]) begin
				div_s3[k].x       <= div_step(div_s3[k-1].x);
				div_s3[k].y       <= div_step(div_s3[k-1].y);
				div_s3[k].touched <= div_s3[k-1].touched;
			end
		end
		if (out_rdy && div_vld_s3[DIV_STEPS-1]) begin
			x_pos_q   <= axis_pos(div_s3[DIV_STEPS-1].x);
			y_pos_q   <= axis_pos(div_s3[DIV_STEPS-1].y);
			touched_q <= div_s3[DIV_STEPS-1].touched;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_BITS'({y_pos_q, x_pos_q});
	assign m_tuser  = touched_q;

	// Input is refused only when the front, multiply, first and last divider and output stages hold a sample
	a_full_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_s1 && vld_s2 && div_vld_s3[0] && div_vld_s3[DIV_STEPS-1] && m_tvalid_q))
		else $error("input refused with a bubble in the pipeline");

	// A stalled front stage keeps its sample
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !rdy_s2) |=> (vld_s1 && $stable(dat_s1)))
		else $error("front stage lost its sample under stall");

	// X remainder after the first divider stage stays below the divisor on the scaled path
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(div_vld_s3[0] && !div_s3[0].x.zero && !div_s3[0].x.sat) |->
		(div_s3[0].x.rem < div_s3[0].x.delta))
		else $error("divider remainder out of range");

	// Y quotient never passes the span on the scaled path
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(div_vld_s3[DIV_STEPS-1] && !div_s3[DIV_STEPS-1].y.zero
		&& !div_s3[DIV_STEPS-1].y.sat) |->
		(div_s3[DIV_STEPS-1].y.work <= div_s3[DIV_STEPS-1].y.span))
		else $error("scaled coordinate above span");

endmodule
